### src/urde_pkg.sv
package urde_pkg;

   localparam int TABLE_DEPTH_DEF = 128;
   localparam int VALUE_BITS_DEF  = 32;

   localparam int OP_W    = 2;
   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 6;
   localparam int DIGIT_W = 7;

   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND  = 2'd1;
   localparam logic [OP_W-1:0] OP_CONVERT = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_LOW   = 8'd32;   // this and below rejected
   localparam logic [CHAR_W-1:0] CHAR_HIGH  = 8'd126;  // above this rejected
   localparam int                MIN_BASE   = 2;
   localparam int                SEEN_DEPTH = 128;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [CHAR_W-1:0]  alphabet_char;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]  digit_char;
      logic               last;
      logic               failed;
      logic [COUNT_W-1:0] written_count;
   } rsp_type;

   typedef struct packed {
      logic              clear;
      logic              append;
      logic [CHAR_W-1:0] ch;
   } alpha_cmd_type;

   typedef struct packed {
      logic bad;
      logic too_short;
   } alpha_stat_type;

   typedef struct packed {
      logic done;
      logic quot_nonzero;
   } div_stat_type;

endpackage

### src/unsigned_radix_digit_emitter_top.sv
// Unsigned value to digit string in the base set by a stored alphabet.
// Request channel: an item is taken at a clock edge with start high and busy
// low. Operation clear empties the alphabet, append adds one character; both
// finish at the accepting edge and leave busy low. Convert turns value into
// digit characters, most significant first.
// Result channel: each beat is on rsp_data for exactly one cycle, marked by
// rsp_strobe. The receiver cannot stall; every beat must be taken as it comes.
// A convert on an invalid or too short alphabet gives one failed beat in the
// cycle after acceptance and keeps busy low.
// Sequence: each digit takes one pass of the bit-serial divider, one quotient
// bit per cycle. After the last division the digits come out of the digit
// stack and alphabet table, each beat passing through states POP, TBL and OUT
// (two registered memory reads per beat). The last beat appears in the same
// cycle that busy falls.
// Reset (synchronous) empties the alphabet, clears the bad flag and the
// character marks, and returns the sequencer to idle; no clearing pass.
module unsigned_radix_digit_emitter_top #(
   parameter int TABLE_DEPTH = urde_pkg::TABLE_DEPTH_DEF,
   parameter int VALUE_BITS  = urde_pkg::VALUE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  urde_pkg::req_type req_data,
   output logic              rsp_strobe,
   output urde_pkg::rsp_type rsp_data
);
   import urde_pkg::*;

   localparam int LEN_BITS  = $clog2(TABLE_DEPTH + 1);
   localparam int CNT_BITS  = $clog2(VALUE_BITS + 1);
   localparam int ADDR_BITS = $clog2(VALUE_BITS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_POP  = 3'd2;
   localparam logic [2:0] S_TBL  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [CNT_BITS-1:0]   n_ff, n_in;
   logic [CNT_BITS-1:0]   pop_ff, pop_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  accept;
   alpha_cmd_type         alpha_cmd;
   alpha_stat_type        alpha_stat;
   logic [LEN_BITS-1:0]   alpha_len;
   logic [CHAR_W-1:0]     table_char;
   logic                  div_start;
   logic [VALUE_BITS-1:0] div_operand;
   logic [VALUE_BITS-1:0] div_quot;
   logic [LEN_BITS-1:0]   div_rem;
   div_stat_type          div_stat;
   logic                  stack_we;
   logic [DIGIT_W-1:0]    stack_rd;
   logic [ADDR_BITS-1:0]  stack_waddr;
   logic [ADDR_BITS-1:0]  stack_raddr;
   logic [CNT_BITS-1:0]   n_inc;
   logic [CNT_BITS-1:0]   pop_dec;
   logic                  push_ok;
   logic                  is_last;

   assign accept      = start && !busy;
   assign n_inc       = n_ff + 1'b1;
   assign pop_dec     = pop_ff - 1'b1;
   assign push_ok     = n_ff < CNT_BITS'(VALUE_BITS);
   assign stack_waddr = n_ff[ADDR_BITS-1:0];
   assign stack_raddr = pop_dec[ADDR_BITS-1:0];
   assign is_last     = pop_ff == CNT_BITS'(1);

   urde_alphabet #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .LEN_BITS    (LEN_BITS)
   ) u_alphabet (
      .clock   (clock),
      .reset   (reset),
      .cmd     (alpha_cmd),
      .rd_idx  (stack_rd),
      .rd_char (table_char),
      .length  (alpha_len),
      .stat    (alpha_stat)
   );

   urde_divider #(
      .VALUE_BITS (VALUE_BITS),
      .LEN_BITS   (LEN_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .operand   (div_operand),
      .divisor   (alpha_len),
      .quotient  (div_quot),
      .remainder (div_rem),
      .stat      (div_stat)
   );

   urde_digit_stack #(
      .VALUE_BITS (VALUE_BITS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_digit_stack (
      .clock    (clock),
      .wr_en    (stack_we),
      .wr_addr  (stack_waddr),
      .wr_digit (div_rem[DIGIT_W-1:0]),
      .rd_addr  (stack_raddr),
      .rd_digit (stack_rd)
   );

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      pop_in        = pop_ff;
      div_start     = 1'b0;
      div_operand   = div_quot;
      alpha_cmd     = '0;
      stack_we      = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.operation)
                  OP_CLEAR: begin
                     alpha_cmd.clear = 1'b1;
                  end
                  OP_APPEND: begin
                     alpha_cmd.append = 1'b1;
                     alpha_cmd.ch     = req_data.alphabet_char;
                  end
                  OP_CONVERT: begin
                     if (alpha_stat.bad || alpha_stat.too_short) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_data_in.last   = 1'b1;
                        rsp_data_in.failed = 1'b1;
                     end else begin
                        div_start   = 1'b1;
                        div_operand = VALUE_BITS'(req_data.value);
                        n_in        = '0;
                        state_in    = S_DIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               stack_we = push_ok;
               if (push_ok) begin
                  n_in = n_inc;
               end
               if (div_stat.quot_nonzero) begin
                  div_start = 1'b1;
               end else begin
                  pop_in   = push_ok ? n_inc : n_ff;
                  state_in = S_POP;
               end
            end
         end
         S_POP: begin
            state_in = S_TBL;
         end
         S_TBL: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_strobe_in          = 1'b1;
            rsp_data_in.digit_char = table_char;
            rsp_data_in.last       = is_last;
            rsp_data_in.written_count = is_last ? COUNT_W'(n_ff) : '0;
            pop_in   = pop_dec;
            state_in = is_last ? S_IDLE : S_POP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         n_ff          <= '0;
         pop_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         n_ff          <= n_in;
         pop_ff        <= pop_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

### src/urde_alphabet.sv
module urde_alphabet #(
   parameter int TABLE_DEPTH = urde_pkg::TABLE_DEPTH_DEF,
   parameter int LEN_BITS    = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  urde_pkg::alpha_cmd_type         cmd,
   input  logic [urde_pkg::DIGIT_W-1:0]    rd_idx,
   output logic [urde_pkg::CHAR_W-1:0]     rd_char,
   output logic [LEN_BITS-1:0]             length,
   output urde_pkg::alpha_stat_type        stat
);
   import urde_pkg::*;

   localparam int IDX_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CMP_W    = (LEN_BITS > DIGIT_W) ? LEN_BITS : DIGIT_W;

   logic [CHAR_W-1:0]     table_mem [TABLE_DEPTH];
   logic [LEN_BITS-1:0]   length_ff, length_in;
   logic                  bad_ff, bad_in;
   logic [SEEN_DEPTH-1:0] seen_ff, seen_in;
   logic [CHAR_W-1:0]     rd_data_ff;
   logic                  rd_hit_ff;
   logic                  full;
   logic                  rejected;
   logic                  do_write;
   logic [IDX_BITS-1:0]   wr_index;
   logic [IDX_BITS-1:0]   rd_index;
   logic                  rd_hit;

   assign full     = length_ff >= LEN_BITS'(TABLE_DEPTH);
   assign rejected = (cmd.ch == CHAR_PLUS) || (cmd.ch == CHAR_MINUS) ||
                     (cmd.ch <= CHAR_LOW) || (cmd.ch > CHAR_HIGH);
   assign do_write = cmd.append && !full;
   assign wr_index = length_ff[IDX_BITS-1:0];
   assign rd_index = IDX_BITS'(rd_idx);
   assign rd_hit   = CMP_W'(rd_idx) < CMP_W'(length_ff);

   always_comb begin
      length_in = length_ff;
      bad_in    = bad_ff;
      seen_in   = seen_ff;
      if (cmd.clear) begin
         length_in = '0;
         bad_in    = 1'b0;
         seen_in   = '0;
      end else if (cmd.append) begin
         if (full) begin
            bad_in = 1'b1;
         end else begin
            length_in = length_ff + 1'b1;
            if (rejected || seen_ff[cmd.ch[DIGIT_W-1:0]]) begin
               bad_in = 1'b1;
            end else begin
               seen_in[cmd.ch[DIGIT_W-1:0]] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         bad_ff    <= 1'b0;
         seen_ff   <= '0;
      end else begin
         length_ff <= length_in;
         bad_ff    <= bad_in;
         seen_ff   <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         table_mem[wr_index] <= cmd.ch;
      end
      rd_data_ff <= table_mem[rd_index];
      rd_hit_ff  <= rd_hit;
   end

   assign rd_char        = rd_hit_ff ? rd_data_ff : '0;
   assign length         = length_ff;
   assign stat.bad       = bad_ff;
   assign stat.too_short = length_ff < LEN_BITS'(MIN_BASE);

endmodule

### src/urde_divider.sv
module urde_divider #(
   parameter int VALUE_BITS = urde_pkg::VALUE_BITS_DEF,
   parameter int LEN_BITS   = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [VALUE_BITS-1:0]   operand,
   input  logic [LEN_BITS-1:0]     divisor,
   output logic [VALUE_BITS-1:0]   quotient,
   output logic [LEN_BITS-1:0]     remainder,
   output urde_pkg::div_stat_type  stat
);
   import urde_pkg::*;

   localparam int STEP_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

   // restoring division, one quotient bit per cycle; quotient shifts into v
   logic [VALUE_BITS-1:0] v_ff, v_in;
   logic [LEN_BITS-1:0]   rem_ff, rem_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic                  qnz_ff, qnz_in;
   logic [LEN_BITS:0]     trial;
   logic [LEN_BITS:0]     divisor_ext;
   logic                  qbit;

   assign trial       = {rem_ff, v_ff[VALUE_BITS-1]};
   assign divisor_ext = {1'b0, divisor};
   assign qbit        = trial >= divisor_ext;

   always_comb begin
      v_in    = v_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      qnz_in  = qnz_ff;
      if (start) begin
         v_in    = operand;
         rem_in  = '0;
         step_in = STEP_BITS'(VALUE_BITS - 1);
         run_in  = 1'b1;
         qnz_in  = 1'b0;
      end else if (run_ff) begin
         v_in    = {v_ff[VALUE_BITS-2:0], qbit};
         rem_in  = qbit ? LEN_BITS'(trial - divisor_ext) : trial[LEN_BITS-1:0];
         qnz_in  = qnz_ff | qbit;
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      v_ff    <= v_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      qnz_ff  <= qnz_in;
   end

   assign quotient          = v_ff;
   assign remainder         = rem_ff;
   assign stat.done         = done_ff;
   assign stat.quot_nonzero = qnz_ff;

endmodule

### src/urde_digit_stack.sv
module urde_digit_stack #(
   parameter int VALUE_BITS = urde_pkg::VALUE_BITS_DEF,
   parameter int ADDR_BITS  = $clog2(VALUE_BITS)
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_BITS-1:0]         wr_addr,
   input  logic [urde_pkg::DIGIT_W-1:0] wr_digit,
   input  logic [ADDR_BITS-1:0]         rd_addr,
   output logic [urde_pkg::DIGIT_W-1:0] rd_digit
);
   import urde_pkg::*;

   logic [DIGIT_W-1:0] stack_mem [VALUE_BITS];
   logic [DIGIT_W-1:0] rd_digit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_digit;
      end
      rd_digit_ff <= stack_mem[rd_addr];
   end

   assign rd_digit = rd_digit_ff;

endmodule
